// File: hw/rtl/bmp_pkg.sv
package bmp_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    localparam logic [31:0] FILE_HDR_BYTES = 32'd14;
    localparam logic [31:0] INFO_HDR_BYTES = 32'd40;
    localparam logic [31:0] HDR_BYTES      = FILE_HDR_BYTES + INFO_HDR_BYTES;

    localparam logic [31:0] POS_SIG_B      = 32'd0;
    localparam logic [31:0] POS_SIG_M      = 32'd1;
    localparam logic [31:0] POS_OFFSET     = 32'd10;
    localparam logic [31:0] POS_OFFSET_END = 32'd13;
    localparam logic [31:0] POS_WIDTH      = 32'd18;
    localparam logic [31:0] POS_WIDTH_END  = 32'd21;
    localparam logic [31:0] POS_HEIGHT     = 32'd22;
    localparam logic [31:0] POS_HEIGHT_END = 32'd25;
    localparam logic [31:0] POS_BITS_LO    = 32'd28;
    localparam logic [31:0] POS_BITS_HI    = 32'd29;
    localparam logic [31:0] POS_HDR_END    = HDR_BYTES - 32'd1;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [QUEUE_PTR_W:0] QUEUE_FULL = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_SIGNATURE = 2'd1,
        ERR_OFFSET    = 2'd2,
        ERR_FORMAT    = 2'd3
    } t_err;

    typedef struct packed {
        t_kind       kind;
        t_err        err;
        logic [7:0]  data_byte;
        logic        row_end;
        logic        last;
        logic [12:0] width;
        logic [12:0] height;
        logic [2:0]  bpp;
        logic [26:0] total;
        logic [26:0] base;
        logic [14:0] row_bytes;
        logic        top_down;
    } t_cmd;

endpackage

// File: hw/rtl/bmp_in_if.sv
interface bmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       first_byte;

    modport source (output valid, output file_byte, output first_byte, input ready);
    modport sink (input valid, input file_byte, input first_byte, output ready);
endinterface

// File: hw/rtl/bmp_out_if.sv
interface bmp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [1:0]  error_code;
    logic [25:0] pixel_address;
    logic [7:0]  pixel_byte;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [2:0]  bytes_per_pixel;
    logic [26:0] image_bytes;
    logic        last_pixel;

    modport source (
        output valid, output result_kind, output error_code, output pixel_address,
        output pixel_byte, output image_width, output image_height,
        output bytes_per_pixel, output image_bytes, output last_pixel,
        input ready
    );
    modport sink (
        input valid, input result_kind, input error_code, input pixel_address,
        input pixel_byte, input image_width, input image_height,
        input bytes_per_pixel, input image_bytes, input last_pixel,
        output ready
    );
endinterface

// File: hw/rtl/bmp_front.sv
module bmp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmp_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output bmp_pkg::t_cmd o_cmd
);
    import bmp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_PAD,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_off, n_off;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [15:0] r_bc, n_bc;
    logic [14:0] r_col, n_col;
    logic [1:0]  r_pad, n_pad;
    logic [12:0] r_rows, n_rows;
    logic [14:0] r_rb;
    logic [12:0] r_h13;
    logic [26:0] r_total;
    logic [26:0] r_base;

    logic        accept;
    t_phase      phase;
    logic [31:0] pos;
    logic [31:0] h_abs;
    logic        format_ok;
    logic [14:0] col_inc;
    logic [12:0] rows_dec;
    logic [1:0]  pad_dec;
    logic [1:0]  row_pad;
    logic [14:0] rb_full;
    logic [27:0] total_full;
    logic [27:0] base_full;

    function automatic logic [31:0] set_lane(input logic [31:0] word, input logic [1:0] lane,
                                             input logic [7:0] value);
        logic [31:0] res;
        res = word;
        res[{lane, 3'b000} +: 8] = value;
        return res;
    endfunction

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign phase      = i_in.first_byte ? PH_HEADER : r_phase;
    assign pos        = i_in.first_byte ? 32'd0 : r_pos;

    assign h_abs     = r_height[31] ? (32'd0 - r_height) : r_height;
    assign format_ok = (r_bc == 16'd8 || r_bc == 16'd16 || r_bc == 16'd24 || r_bc == 16'd32) &&
                       (r_width != 32'd0) && (r_width <= MAX_WIDTH) &&
                       (h_abs != 32'd0) && (h_abs <= MAX_HEIGHT);

    assign col_inc  = r_col + 15'd1;
    assign rows_dec = r_rows - 13'd1;
    assign pad_dec  = r_pad - 2'd1;
    assign row_pad  = 2'd0 - r_rb[1:0];

    assign rb_full    = {2'd0, r_width[12:0]} * {12'd0, r_bc[5:3]};
    assign total_full = {13'd0, r_rb} * {15'd0, r_h13};
    assign base_full  = {13'd0, r_rb} * {15'd0, r_h13 - 13'd1};

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_off    = r_off;
        n_width  = r_width;
        n_height = r_height;
        n_bc     = r_bc;
        n_col    = r_col;
        n_pad    = r_pad;
        n_rows   = r_rows;
        o_push   = 1'b0;
        o_cmd    = '0;
        if (accept) begin
            n_phase = phase;
            if (i_in.first_byte) begin
                n_off    = '0;
                n_width  = '0;
                n_height = '0;
                n_bc     = '0;
            end
            case (phase)
                PH_HEADER: begin
                    if (pos >= POS_OFFSET && pos <= POS_OFFSET_END) begin
                        n_off = set_lane(n_off, 2'(pos - POS_OFFSET), i_in.file_byte);
                    end
                    if (pos >= POS_WIDTH && pos <= POS_WIDTH_END) begin
                        n_width = set_lane(n_width, 2'(pos - POS_WIDTH), i_in.file_byte);
                    end
                    if (pos >= POS_HEIGHT && pos <= POS_HEIGHT_END) begin
                        n_height = set_lane(n_height, 2'(pos - POS_HEIGHT), i_in.file_byte);
                    end
                    if (pos == POS_BITS_LO) begin
                        n_bc[7:0] = i_in.file_byte;
                    end
                    if (pos == POS_BITS_HI) begin
                        n_bc[15:8] = i_in.file_byte;
                    end
                    if ((pos == POS_SIG_B && i_in.file_byte != SIG_B) ||
                        (pos == POS_SIG_M && i_in.file_byte != SIG_M)) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_ERROR;
                        o_cmd.err  = ERR_SIGNATURE;
                        n_phase    = PH_DONE;
                    end else if (pos == POS_OFFSET_END && n_off < HDR_BYTES) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_ERROR;
                        o_cmd.err  = ERR_OFFSET;
                        n_phase    = PH_DONE;
                    end else if (pos == POS_HDR_END) begin
                        o_push = 1'b1;
                        if (!format_ok) begin
                            o_cmd.kind = KIND_ERROR;
                            o_cmd.err  = ERR_FORMAT;
                            n_phase    = PH_DONE;
                        end else begin
                            o_cmd.kind      = KIND_HEADER;
                            o_cmd.width     = r_width[12:0];
                            o_cmd.height    = r_h13;
                            o_cmd.bpp       = r_bc[5:3];
                            o_cmd.total     = r_total;
                            o_cmd.base      = r_height[31] ? 27'd0 : r_base;
                            o_cmd.row_bytes = r_rb;
                            o_cmd.top_down  = r_height[31];
                            n_col   = '0;
                            n_pad   = '0;
                            n_rows  = r_h13;
                            n_phase = (r_off == HDR_BYTES) ? PH_PIXEL : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (r_pos + 32'd1 == r_off) begin
                        n_phase = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    o_push          = 1'b1;
                    o_cmd.kind      = KIND_PIXEL;
                    o_cmd.data_byte = i_in.file_byte;
                    if (col_inc == r_rb) begin
                        o_cmd.row_end = 1'b1;
                        n_col         = '0;
                        n_rows        = rows_dec;
                        if (rows_dec == 13'd0) begin
                            o_cmd.last = 1'b1;
                            n_phase    = PH_DONE;
                        end else begin
                            n_pad   = row_pad;
                            n_phase = (row_pad != 2'd0) ? PH_PAD : PH_PIXEL;
                        end
                    end else begin
                        n_col = col_inc;
                    end
                end
                PH_PAD: begin
                    n_pad = pad_dec;
                    if (pad_dec == 2'd0) begin
                        n_phase = PH_PIXEL;
                    end
                end
                default: begin
                end
            endcase
            if (phase != PH_IDLE) begin
                n_pos = pos + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pos    <= '0;
            r_off    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_bc     <= '0;
            r_col    <= '0;
            r_pad    <= '0;
            r_rows   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_off    <= n_off;
            r_width  <= n_width;
            r_height <= n_height;
            r_bc     <= n_bc;
            r_col    <= n_col;
            r_pad    <= n_pad;
            r_rows   <= n_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rb    <= rb_full;
        r_h13   <= h_abs[12:0];
        r_total <= total_full[26:0];
        r_base  <= base_full[26:0];
    end

endmodule

// File: hw/rtl/bmp_queue.sv
module bmp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bmp_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output bmp_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import bmp_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    assign o_full  = (r_count == QUEUE_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/bmp_back.sv
module bmp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bmp_pkg::t_cmd i_cmd,
    output logic          o_pop,
    bmp_out_if.source     o_out
);
    import bmp_pkg::*;

    typedef struct packed {
        t_kind       kind;
        t_err        err;
        logic [25:0] addr;
        logic [7:0]  data_byte;
        logic [12:0] width;
        logic [12:0] height;
        logic [2:0]  bpp;
        logic [26:0] total;
        logic        last;
    } t_result;

    logic [2:0]  r_bpp, n_bpp;
    logic [14:0] r_rb, n_rb;
    logic        r_top, n_top;
    logic [26:0] r_row_base, n_row_base;
    logic [26:0] r_pix_base, n_pix_base;
    logic [1:0]  r_bip, n_bip;
    logic        r_out_valid, n_out_valid;
    t_result     r_res, n_res;

    logic [2:0]  byte_offset;
    logic [26:0] addr;
    logic [2:0]  bip_inc;
    logic [26:0] next_row;

    assign o_pop       = i_valid && (!r_out_valid || o_out.ready);
    assign byte_offset = r_bpp - 3'd1 - {1'b0, r_bip};
    assign addr        = r_pix_base + {24'd0, byte_offset};
    assign bip_inc     = {1'b0, r_bip} + 3'd1;
    assign next_row    = r_top ? (r_row_base + {12'd0, r_rb}) : (r_row_base - {12'd0, r_rb});

    always_comb begin
        n_bpp       = r_bpp;
        n_rb        = r_rb;
        n_top       = r_top;
        n_row_base  = r_row_base;
        n_pix_base  = r_pix_base;
        n_bip       = r_bip;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_out.ready;
        if (o_pop) begin
            n_out_valid = 1'b1;
            n_res       = '0;
            n_res.kind  = i_cmd.kind;
            case (i_cmd.kind)
                KIND_HEADER: begin
                    n_bpp        = i_cmd.bpp;
                    n_rb         = i_cmd.row_bytes;
                    n_top        = i_cmd.top_down;
                    n_row_base   = i_cmd.base;
                    n_pix_base   = i_cmd.base;
                    n_bip        = '0;
                    n_res.width  = i_cmd.width;
                    n_res.height = i_cmd.height;
                    n_res.bpp    = i_cmd.bpp;
                    n_res.total  = i_cmd.total;
                end
                KIND_ERROR: begin
                    n_res.err = i_cmd.err;
                end
                KIND_PIXEL: begin
                    n_res.addr      = addr[25:0];
                    n_res.data_byte = i_cmd.data_byte;
                    n_res.last      = i_cmd.last;
                    if (i_cmd.row_end) begin
                        n_bip      = '0;
                        n_row_base = next_row;
                        n_pix_base = next_row;
                    end else if (bip_inc >= r_bpp) begin
                        n_bip      = '0;
                        n_pix_base = r_pix_base + {24'd0, r_bpp};
                    end else begin
                        n_bip = bip_inc[1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bip       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_bip       <= n_bip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bpp      <= n_bpp;
        r_rb       <= n_rb;
        r_top      <= n_top;
        r_row_base <= n_row_base;
        r_pix_base <= n_pix_base;
        r_res      <= n_res;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.result_kind     = r_res.kind;
    assign o_out.error_code      = r_res.err;
    assign o_out.pixel_address   = r_res.addr;
    assign o_out.pixel_byte      = r_res.data_byte;
    assign o_out.image_width     = r_res.width;
    assign o_out.image_height    = r_res.height;
    assign o_out.bytes_per_pixel = r_res.bpp;
    assign o_out.image_bytes     = r_res.total;
    assign o_out.last_pixel      = r_res.last;

endmodule

// File: hw/rtl/bmp_stream_decoder.sv
// Byte-serial decoder for uncompressed BMP files.
// The input channel takes one file byte per transaction; first_byte marks the
// start of a new file and restarts the parse at any time. Bytes seen before
// any first byte, after an error, or after the last pixel produce nothing.
// The output channel carries one transaction per header result, error or
// pixel byte; each pixel byte carries its frame address in a top-down frame.
// The parser takes one byte per clock cycle when the sink keeps up,
// including header, skip and row padding bytes. Each result passes through
// the command queue and the output register on its way to the output.
// Header sizes are precomputed by three registered multipliers while the
// remaining header bytes stream in.
// A four-entry command queue sits between the parser and the address
// generator. When the sink stalls, the output register holds its transaction,
// the queue fills, and then the input ready drops until space frees up.
// After reset the parser waits for a first byte, the queue is empty and the
// output holds no transaction.
module bmp_stream_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmp_in_if.sink    i_in,
    bmp_out_if.source o_out
);
    import bmp_pkg::*;

    logic push;
    t_cmd push_cmd;
    logic full;
    logic head_valid;
    t_cmd head_cmd;
    logic pop;

    bmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    bmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    bmp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
